FILE: hw/rtl/timing_display_frame_decoder_macros.svh
// Assertion macros used by the checker file of the frame decoder.
`ifndef TIMING_DISPLAY_FRAME_DECODER_MACROS_SVH
`define TIMING_DISPLAY_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TDFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TDFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tdfd_pkg.sv
// Constants, channel length table and control types of the frame decoder.
package tdfd_pkg;

  localparam int NUM_CHANNELS = 32;
  localparam int ROW_DIGITS   = 16;
  localparam int FRAME_DEPTH  = 9;
  localparam int CHAN_W       = $clog2(NUM_CHANNELS);
  localparam int ROW_W        = 4 * ROW_DIGITS;
  localparam int COUNT_W      = 4;
  localparam logic [ROW_W-1:0] ROW_RESET = {ROW_DIGITS{4'h1}};

  // Frame length in bytes, address word included; zero means never closes.
  function automatic logic [COUNT_W-1:0] chan_len(input logic [CHAN_W-1:0] ch);
    logic [COUNT_W-1:0] len;
    case (ch)
      5'd0:                                   len = 4'd7;
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
      5'd7, 5'd8, 5'd9, 5'd10, 5'd12, 5'd14,
      5'd15, 5'd17, 5'd18:                    len = 4'd9;
      5'd22:                                  len = 4'd5;
      default:                                len = 4'd0;
    endcase
    return len;
  endfunction

  typedef struct packed {
    logic take;    // input byte transfer this cycle
    logic commit;  // merge row, write back and load the result register
  } tdfd_cmd_t;

  typedef struct packed {
    logic close_hit;  // incoming byte closes a complete frame
    logic out_busy;   // result register still held by the receiver
  } tdfd_sts_t;

endpackage

FILE: hw/rtl/tdfd_byte_if.sv
// Byte stream channel: valid/ready handshake carrying one received byte.
interface tdfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/tdfd_row_if.sv
// Result channel: valid/ready handshake carrying a channel and its digit row.
interface tdfd_row_if;
  logic        valid;
  logic        ready;
  logic [4:0]  channel;
  logic [63:0] row_digits;

  modport source (output valid, output channel, output row_digits, input ready);
  modport sink   (input valid, input channel, input row_digits, output ready);
endinterface

FILE: hw/rtl/tdfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tdfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/tdfd_ctrl.sv
// Controller: accepts bytes and sequences the row read-merge-write on frame close.
module tdfd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  tdfd_pkg::tdfd_sts_t sts,
  output tdfd_pkg::tdfd_cmd_t cmd
);
  import tdfd_pkg::*;

  typedef enum logic [0:0] {
    IDLE,
    MERGE
  } state_t;

  state_t state;

  always_comb begin
    rx_ready   = (state == IDLE);
    cmd.take   = rx_valid && rx_ready;
    cmd.commit = (state == MERGE) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.take && sts.close_hit) begin
            state <= MERGE;
          end
        end
        MERGE: begin
          if (cmd.commit) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/tdfd_dp.sv
// Datapath: frame parser, frame byte buffer, row store and result register.
module tdfd_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [7:0]                         rx_byte,
  input  tdfd_pkg::tdfd_cmd_t                cmd,
  output tdfd_pkg::tdfd_sts_t                sts,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [tdfd_pkg::CHAN_W-1:0]        channel,
  output logic [tdfd_pkg::ROW_W-1:0]         row_digits
);
  import tdfd_pkg::*;

  logic                 in_frame;
  logic [COUNT_W-1:0]   byte_count;
  logic [CHAN_W-1:0]    cur_channel;
  logic                 cur_half;
  logic [7:0]           frame_bytes [1:FRAME_DEPTH-1];

  logic [CHAN_W-1:0]    close_channel;
  logic                 close_half;
  logic [COUNT_W-1:0]   close_len;
  logic [NUM_CHANNELS-1:0] row_valid;

  logic [ROW_W-1:0]     row_rdata;
  logic [ROW_W-1:0]     row_base;
  logic [ROW_W-1:0]     row_merged;
  logic [COUNT_W-1:0]   cur_len;

  assign cur_len = chan_len(cur_channel);

  always_comb begin
    sts.close_hit = rx_byte[7] && in_frame && (cur_len != '0) && (byte_count == cur_len);
    sts.out_busy  = out_valid && !out_ready;
  end

  // Parser state and frame buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_count  <= '0;
      cur_channel <= '0;
      cur_half    <= 1'b0;
    end else if (cmd.take) begin
      if (rx_byte[7]) begin
        in_frame    <= 1'b1;
        byte_count  <= COUNT_W'(1);
        cur_half    <= rx_byte[0];
        cur_channel <= ~rx_byte[5:1];
      end else if (in_frame) begin
        byte_count <= byte_count + COUNT_W'(1);
        // ninth data byte overflows the buffer and kills the frame
        if (byte_count == COUNT_W'(FRAME_DEPTH)) begin
          in_frame <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && !rx_byte[7] && in_frame) begin
      for (int k = 1; k < FRAME_DEPTH; k++) begin
        if (byte_count == COUNT_W'(k)) begin
          frame_bytes[k] <= rx_byte;
        end
      end
    end
  end

  // Snapshot of the closing frame; buffer entries stay intact until next data byte
  always_ff @(posedge clk) begin
    if (cmd.take && rx_byte[7]) begin
      close_channel <= cur_channel;
      close_half    <= cur_half;
      close_len     <= cur_len;
    end
  end

  tdfd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_CHANNELS)
  ) u_row_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (close_channel),
    .wdata (row_merged),
    .re    (cmd.take),
    .raddr (cur_channel),
    .rdata (row_rdata)
  );

  // Rows never written read as the reset pattern
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.commit) begin
      row_valid[close_channel] <= 1'b1;
    end
  end

  assign row_base = row_valid[close_channel] ? row_rdata : ROW_RESET;

  // Per-digit merge; later bytes of the frame take priority
  always_comb begin
    row_merged = row_base;
    for (int i = 0; i < ROW_DIGITS; i++) begin
      for (int k = 1; k < FRAME_DEPTH; k++) begin
        if ((COUNT_W'(k) < close_len) &&
            ({frame_bytes[k][6:4], close_half} == 4'(i))) begin
          row_merged[4*i +: 4] = ~frame_bytes[k][3:0];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      channel    <= close_channel;
      row_digits <= row_merged;
    end
  end

endmodule

FILE: hw/rtl/timing_display_frame_decoder.sv
// Top level of the timing display frame decoder.
// Takes one byte per transfer on rx. A byte with bit 7 set is an address word
// (channel = inverted bits 5:1, half = bit 0); data bytes after it are buffered.
// When the next address word arrives and the open frame has its channel's
// fixed length, each data byte writes its inverted low nibble into the
// channel's 16-digit row and the updated row is sent on frame. Data bytes and
// non-closing address words are taken back to back; a closing address word
// reads the row store, then the MERGE state merges and writes back the row
// and loads the result register, waiting while the receiver still holds the
// previous result; rx is not ready meanwhile. Rows live in a 32 x 64 RAM with
// one valid flag per row, so no clearing pass is needed after reset.
module timing_display_frame_decoder (
  input logic          clk,
  input logic          rst,
  tdfd_byte_if.sink    rx,
  tdfd_row_if.source   frame
);
  import tdfd_pkg::*;

  tdfd_cmd_t cmd;
  tdfd_sts_t sts;

  tdfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdfd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx.rx_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (frame.ready),
    .out_valid  (frame.valid),
    .channel    (frame.channel),
    .row_digits (frame.row_digits)
  );

endmodule

FILE: hw/rtl/tdfd_checker.sv
// Port-level checker for the frame decoder, bound to the top level.
`include "timing_display_frame_decoder_macros.svh"

module tdfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_valid,
  input logic        rx_ready,
  input logic [7:0]  rx_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  channel,
  input logic [63:0] row_digits
);
  import tdfd_pkg::*;

  `TDFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `TDFD_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(channel) && $stable(row_digits), "result changed while stalled")
  `TDFD_ASSERT_NOW(a_chan_closable, clk, rst, out_valid, chan_len(channel) != '0, "result for a channel that never closes")
  `TDFD_ASSERT_NEXT(a_data_no_result, clk, rst, rx_valid && rx_ready && !rx_byte[7], !$rose(out_valid), "result after a data byte")

endmodule

bind timing_display_frame_decoder tdfd_checker u_tdfd_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_valid   (rx.valid),
  .rx_ready   (rx.ready),
  .rx_byte    (rx.rx_byte),
  .out_valid  (frame.valid),
  .out_ready  (frame.ready),
  .channel    (frame.channel),
  .row_digits (frame.row_digits)
);
